/* hw/rtl/twd_pkg.sv */
// ----------------------------------------------------------------------------
// twd_pkg
// Operation codes, symbol alphabet and character folding for the trie
// word dictionary.
// ----------------------------------------------------------------------------
`default_nettype none

package twd_pkg;

	localparam int SYMBOL_COUNT = 27;
	localparam int SYM_W        = 5;
	localparam int COUNT_W      = 24;
	localparam int OP_W         = 3;
	localparam int CHAR_W       = 8;

	localparam logic [COUNT_W-1:0] COUNT_MAX     = {COUNT_W{1'b1}};
	localparam logic [CHAR_W-1:0]  CHAR_LOWER_A  = 8'h61;
	localparam logic [CHAR_W-1:0]  CHAR_UPPER_A  = 8'h41;
	localparam logic [CHAR_W-1:0]  CHAR_APOS     = 8'h27;
	localparam logic [CHAR_W-1:0]  LETTER_COUNT  = 8'd26;
	localparam logic [SYM_W-1:0]   SYM_APOS      = 5'd26;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR    = 3'd0,
		OP_INS_CHAR = 3'd1,
		OP_INS_END  = 3'd2,
		OP_CHK_CHAR = 3'd3,
		OP_CHK_END  = 3'd4
	} op_t;

	typedef struct packed {
		logic             valid;
		logic [SYM_W-1:0] code;
	} sym_t;

	// Fold upper case onto lower case; apostrophe is the last slot.
	function automatic sym_t symbol_of(input logic [CHAR_W-1:0] ch);
		sym_t              s;
		logic [CHAR_W-1:0] diff;
		s.valid = 1'b0;
		s.code  = '0;
		diff    = '0;
		if (ch >= CHAR_LOWER_A && ch < CHAR_LOWER_A + LETTER_COUNT) begin
			diff    = ch - CHAR_LOWER_A;
			s.valid = 1'b1;
			s.code  = diff[SYM_W-1:0];
		end else if (ch >= CHAR_UPPER_A && ch < CHAR_UPPER_A + LETTER_COUNT) begin
			diff    = ch - CHAR_UPPER_A;
			s.valid = 1'b1;
			s.code  = diff[SYM_W-1:0];
		end else if (ch == CHAR_APOS) begin
			s.valid = 1'b1;
			s.code  = SYM_APOS;
		end
		return s;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/twd_in_if.sv */
// ----------------------------------------------------------------------------
// twd_in_if
// Input channel: one operation and one character per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface twd_in_if;
	logic                         valid;
	logic                         ready;
	logic [twd_pkg::OP_W-1:0]     operation;
	logic [twd_pkg::CHAR_W-1:0]   character;

	modport source (output valid, output operation, output character, input ready);
	modport sink   (input valid, input operation, input character, output ready);
endinterface

`default_nettype wire

/* hw/rtl/twd_out_if.sv */
// ----------------------------------------------------------------------------
// twd_out_if
// Result channel: one word result per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface twd_out_if;
	logic                          valid;
	logic                          ready;
	logic                          found;
	logic [twd_pkg::COUNT_W-1:0]   word_count;
	logic                          error;

	modport source (output valid, output found, output word_count, output error, input ready);
	modport sink   (input valid, input found, input word_count, input error, output ready);
endinterface

`default_nettype wire

/* hw/rtl/twd_node_ram.sv */
// ----------------------------------------------------------------------------
// twd_node_ram
// Node row memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module twd_node_ram #(
	parameter int DEPTH  = 4096,
	parameter int ADDR_W = 12,
	parameter int DATA_W = 325
) (
	input  wire logic              clk,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [DATA_W-1:0] rd_data,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [DATA_W-1:0] wr_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/trie_word_dictionary_core.sv */
// ----------------------------------------------------------------------------
// trie_word_dictionary_core
// 27-symbol trie dictionary over a fixed node pool held in one row memory.
// ----------------------------------------------------------------------------
// Each node is one memory row holding its 27 child indices and its word-end
// mark. A valid character is accepted with a row read and looked up once the
// registered row is back, as the next cursor is only known then; if it
// allocates a node, the new row is then zeroed in the wipe state. Ignored or
// invalid characters finish at accept; end items are looked up and wait on a
// full result register; clear passes through the wipe state. Rows at or
// above the allocation pointer are never read, so reset and clear only zero
// the root row: the first transaction is taken in the cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module trie_word_dictionary_core #(
	parameter int NODE_COUNT = 4096
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	twd_in_if.sink     item,
	twd_out_if.source  result
);

	localparam int IDX_W  = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int FREE_W = IDX_W + 1;
	localparam int ROW_W  = twd_pkg::SYMBOL_COUNT * IDX_W + 1;
	localparam int MARK   = ROW_W - 1;

	typedef enum logic [2:0] {
		ST_WIPE   = 3'b001,
		ST_IDLE   = 3'b010,
		ST_LOOKUP = 3'b100
	} state_t;

	state_t                         state_q;
	twd_pkg::op_t                   op_q;
	logic [twd_pkg::SYM_W-1:0]      sym_q;
	logic [IDX_W-1:0]               cursor_q;
	logic [FREE_W-1:0]              next_free_q;
	logic                           missed_q;
	logic                           err_q;
	logic [twd_pkg::COUNT_W-1:0]    words_q;
	logic                           out_valid_q;
	logic                           found_q;
	logic [twd_pkg::COUNT_W-1:0]    count_q;
	logic                           error_q;

	logic [ROW_W-1:0]               rd_data;
	logic [ROW_W-1:0]               row_alloc;
	logic [ROW_W-1:0]               row_mark;
	logic [ROW_W-1:0]               wr_data;
	logic [IDX_W-1:0]               child;
	logic                           child_hit;
	logic                           can_alloc;
	logic                           out_free;
	logic                           in_fire;
	twd_pkg::sym_t                  in_sym;
	logic                           start_lookup;
	logic                           set_err;
	logic                           rd_en;
	logic                           wr_en;
	logic                           emit;
	logic                           found_next;
	logic [twd_pkg::COUNT_W-1:0]    count_next;

	twd_node_ram #(
		.DEPTH  (NODE_COUNT),
		.ADDR_W (IDX_W),
		.DATA_W (ROW_W)
	) u_ram (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (cursor_q),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (cursor_q),
		.wr_data (wr_data)
	);

	assign item.ready = (state_q == ST_IDLE);
	assign in_fire    = item.valid && item.ready;
	assign in_sym     = twd_pkg::symbol_of(item.character);
	assign out_free   = !out_valid_q || result.ready;

	// Decide at accept whether the item needs its cursor row.
	always_comb begin
		start_lookup = 1'b0;
		set_err      = 1'b0;
		unique case (item.operation)
			twd_pkg::OP_INS_CHAR: begin
				if (!err_q) begin
					start_lookup = in_sym.valid;
					set_err      = !in_sym.valid;
				end
			end
			twd_pkg::OP_CHK_CHAR: begin
				if (!err_q && !missed_q) begin
					start_lookup = in_sym.valid;
					set_err      = !in_sym.valid;
				end
			end
			twd_pkg::OP_INS_END, twd_pkg::OP_CHK_END: begin
				start_lookup = 1'b1;
			end
			default: begin
				start_lookup = 1'b0;
			end
		endcase
	end

	assign rd_en = in_fire && start_lookup;

	always_comb begin
		child     = rd_data[sym_q*IDX_W +: IDX_W];
		child_hit = (child != '0);
		can_alloc = (next_free_q < FREE_W'(NODE_COUNT));
		row_alloc = rd_data;
		for (int s = 0; s < twd_pkg::SYMBOL_COUNT; s++) begin
			if (twd_pkg::SYM_W'(s) == sym_q) begin
				row_alloc[s*IDX_W +: IDX_W] = next_free_q[IDX_W-1:0];
			end
		end
		row_mark       = rd_data;
		row_mark[MARK] = 1'b1;
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_data = '0;
		emit    = 1'b0;
		unique case (state_q)
			ST_WIPE: begin
				wr_en = 1'b1;
			end
			ST_LOOKUP: begin
				if (op_q == twd_pkg::OP_INS_CHAR) begin
					wr_en   = !child_hit && can_alloc;
					wr_data = row_alloc;
				end else if (op_q == twd_pkg::OP_INS_END) begin
					wr_en   = !err_q && out_free;
					wr_data = row_mark;
					emit    = out_free;
				end else if (op_q == twd_pkg::OP_CHK_END) begin
					emit = out_free;
				end
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	assign found_next = (op_q == twd_pkg::OP_CHK_END) && !err_q && !missed_q
		&& (cursor_q != '0) && rd_data[MARK];
	assign count_next = ((op_q == twd_pkg::OP_INS_END) && !err_q
		&& (words_q != twd_pkg::COUNT_MAX)) ? words_q + 1'b1 : words_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_WIPE;
			op_q        <= twd_pkg::OP_CLEAR;
			sym_q       <= '0;
			cursor_q    <= '0;
			next_free_q <= FREE_W'(1);
			missed_q    <= 1'b0;
			err_q       <= 1'b0;
			words_q     <= '0;
		end else begin
			unique case (state_q)
				ST_WIPE: begin
					state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_fire) begin
						if (item.operation == twd_pkg::OP_CLEAR) begin
							cursor_q    <= '0;
							next_free_q <= FREE_W'(1);
							missed_q    <= 1'b0;
							err_q       <= 1'b0;
							words_q     <= '0;
							state_q     <= ST_WIPE;
						end else if (start_lookup) begin
							op_q    <= twd_pkg::op_t'(item.operation);
							sym_q   <= in_sym.code;
							state_q <= ST_LOOKUP;
						end else if (set_err) begin
							err_q <= 1'b1;
						end
					end
				end
				ST_LOOKUP: begin
					if (op_q == twd_pkg::OP_INS_CHAR) begin
						if (child_hit) begin
							cursor_q <= child;
							state_q  <= ST_IDLE;
						end else if (can_alloc) begin
							// New node: its row is zeroed next cycle.
							cursor_q    <= next_free_q[IDX_W-1:0];
							next_free_q <= next_free_q + 1'b1;
							state_q     <= ST_WIPE;
						end else begin
							err_q   <= 1'b1;
							state_q <= ST_IDLE;
						end
					end else if (op_q == twd_pkg::OP_CHK_CHAR) begin
						if (child_hit) begin
							cursor_q <= child;
						end else begin
							missed_q <= 1'b1;
						end
						state_q <= ST_IDLE;
					end else if (emit) begin
						words_q  <= count_next;
						cursor_q <= '0;
						missed_q <= 1'b0;
						err_q    <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			found_q <= found_next;
			count_q <= count_next;
			error_q <= err_q;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.found      = found_q;
	assign result.word_count = count_q;
	assign result.error      = error_q;

	// The allocation pointer stays within the pool and never reaches zero.
	a_free_range: assert property (@(posedge clk) disable iff (!arst_n)
		(next_free_q != '0) && (next_free_q <= FREE_W'(NODE_COUNT)))
		else $error("allocation pointer out of range");

	// The cursor always names an allocated node.
	a_cursor_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, cursor_q} < next_free_q)
		else $error("cursor points past the allocated nodes");

	// A result is only produced when the register is free to take it.
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (!out_valid_q || result.ready))
		else $error("result register overwritten");

	// An allocating character always zeroes the new node's row next cycle.
	a_alloc_wipe: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOKUP && op_q == twd_pkg::OP_INS_CHAR && wr_en)
		|=> (state_q == ST_WIPE && wr_en))
		else $error("new node row not cleared");

endmodule

`default_nettype wire

/* tb/tb_trie_word_dictionary_core.sv */
// ----------------------------------------------------------------------------
// tb_trie_word_dictionary_core
// Self-checking bench for the trie word dictionary. A queue of character and
// end transactions feeds a clocked driver. A clocked monitor compares every
// word result against a behavioral dictionary that is updated as each
// transaction is accepted. Stimulus covers directed corner cases and random
// words that are mostly inserts and checks of a growing vocabulary. Both
// sides insert random idle gaps.
// ----------------------------------------------------------------------------
module tb_trie_word_dictionary_core;
	timeunit 1ns;
	timeprecision 1ps;

	import twd_pkg::*;

	localparam int TB_NODES     = 4096;
	localparam int RANDOM_ITEMS = 920;
	localparam int TAIL_CYCLES  = 20;

	localparam logic [OP_W-1:0]   OP_SPARE_FIRST = 3'd5;
	localparam logic [OP_W-1:0]   OP_SPARE_LAST  = 3'd7;
	localparam logic [CHAR_W-1:0] CASE_BIT       = 8'h20;
	localparam int                SEND_SIDE      = 0;
	localparam int                RECV_SIDE      = 1;

	typedef struct {
		logic [OP_W-1:0]   op;
		logic [CHAR_W-1:0] ch;
		bit                hold;
	} dict_item_t;

	typedef struct packed {
		logic               found;
		logic [COUNT_W-1:0] word_count;
		logic               error;
	} word_result_t;

	logic clk = 1'b0;
	logic arst_n;

	twd_in_if  item_ch ();
	twd_out_if result_ch ();

	trie_word_dictionary_core #(
		.NODE_COUNT(TB_NODES)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item_ch),
		.result(result_ch)
	);

	always #5 clk = ~clk;

	dict_item_t   pending_items[$];
	word_result_t expected_word_results[$];
	int           mismatches = 0;
	int           calm_left[2];
	int           send_gap = 0;
	int           stall_left = 0;

	// Dictionary state mirrored by the bench.
	int unsigned       child_of[int];
	bit [TB_NODES-1:0] word_marked;
	int unsigned       at_node;
	int unsigned       pool_next;
	int unsigned       words_total;
	bit                walk_missed;
	bit                walk_error;

	function automatic void clear_dictionary();
		child_of.delete();
		word_marked = '0;
		at_node     = 0;
		pool_next   = 1;
		words_total = 0;
		walk_missed = 1'b0;
		walk_error  = 1'b0;
	endfunction

	// Map a character onto its child slot; -1 for anything else.
	function automatic int fold_symbol(logic [CHAR_W-1:0] c);
		int s;
		s = -1;
		if (c >= "a" && c <= "z")
			s = int'(c - "a");
		else if (c >= "A" && c <= "Z")
			s = int'(c - "A");
		else if (c == "'")
			s = SYMBOL_COUNT - 1;
		return s;
	endfunction

	function automatic void apply_dictionary_item(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch);
		int           sym;
		int unsigned  here;
		int           key;
		bit           closes;
		word_result_t r;
		sym    = fold_symbol(ch);
		here   = (at_node < TB_NODES) ? at_node : 0;
		key    = (sym >= 0) ? int'(here) * SYMBOL_COUNT + sym : 0;
		closes = 1'b0;
		r      = '0;
		case (op)
			OP_CLEAR: clear_dictionary();
			OP_INS_CHAR: begin
				if (!walk_error) begin
					if (sym < 0) begin
						walk_error = 1'b1;
					end else if (child_of.exists(key)) begin
						at_node = child_of[key];
					end else if (pool_next < TB_NODES) begin
						child_of[key] = pool_next;
						at_node       = pool_next;
						pool_next++;
					end else begin
						walk_error = 1'b1;
					end
				end
			end
			OP_CHK_CHAR: begin
				if (!walk_error && !walk_missed) begin
					if (sym < 0)
						walk_error = 1'b1;
					else if (child_of.exists(key))
						at_node = child_of[key];
					else
						walk_missed = 1'b1;
				end
			end
			OP_INS_END: begin
				closes = 1'b1;
				if (!walk_error) begin
					word_marked[here] = 1'b1;
					if (words_total < COUNT_MAX)
						words_total++;
				end
			end
			OP_CHK_END: begin
				closes  = 1'b1;
				r.found = !walk_error && !walk_missed && here != 0 && word_marked[here];
			end
			default: ;
		endcase
		if (closes) begin
			r.word_count = words_total[COUNT_W-1:0];
			r.error      = walk_error;
			expected_word_results.push_back(r);
			at_node     = 0;
			walk_missed = 1'b0;
			walk_error  = 1'b0;
		end
	endfunction

	// Mostly short gaps, a few long ones, and now and then a calm stretch.
	function automatic int idle_length(int side);
		int r;
		if (calm_left[side] > 0) begin
			calm_left[side]--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm_left[side] = $urandom_range(30, 150);
			return 0;
		end
		if (r < 40)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Driver: present queued transactions, predict each one as it is accepted.
	always @(posedge clk or negedge arst_n) begin : driver
		dict_item_t nxt;
		bit         drive;
		if (!arst_n) begin
			item_ch.valid     <= 1'b0;
			item_ch.operation <= OP_CLEAR;
			item_ch.character <= '0;
			send_gap = 0;
		end else begin
			if (item_ch.valid && item_ch.ready) begin
				apply_dictionary_item(item_ch.operation, item_ch.character);
				send_gap = idle_length(SEND_SIDE);
			end
			if (!item_ch.valid || item_ch.ready) begin
				drive = 1'b0;
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_items.size() != 0 &&
				             !(pending_items[0].hold && expected_word_results.size() != 0)) begin
					nxt = pending_items.pop_front();
					item_ch.operation <= nxt.op;
					item_ch.character <= nxt.ch;
					drive = 1'b1;
				end
				item_ch.valid <= drive;
			end
		end
	end

	// Monitor: stall at random and check each result transaction.
	always @(posedge clk or negedge arst_n) begin : monitor
		word_result_t want;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (expected_word_results.size() == 0) begin
					$error("unexpected result: found %0d word_count %0d error %0d",
					       result_ch.found, result_ch.word_count, result_ch.error);
					mismatches++;
				end else begin
					want = expected_word_results.pop_front();
					if (result_ch.found !== want.found) begin
						$error("found: expected %0d, got %0d", want.found, result_ch.found);
						mismatches++;
					end
					if (result_ch.word_count !== want.word_count) begin
						$error("word_count: expected %0d, got %0d",
						       want.word_count, result_ch.word_count);
						mismatches++;
					end
					if (result_ch.error !== want.error) begin
						$error("error: expected %0d, got %0d", want.error, result_ch.error);
						mismatches++;
					end
				end
			end
			if (stall_left == 0 && $urandom_range(0, 3) == 0)
				stall_left = idle_length(RECV_SIDE);
			if (stall_left > 0) begin
				stall_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	task automatic push_item(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch, bit hold);
		dict_item_t it;
		it.op   = op;
		it.ch   = ch;
		it.hold = hold;
		pending_items.push_back(it);
	endtask

	// Queue a word; a fault character, if any, goes in before position fault_at.
	task automatic queue_word(string w, logic [OP_W-1:0] char_op, logic [OP_W-1:0] end_op,
	                          int fault_at, logic [CHAR_W-1:0] fault_ch, bit hold);
		bit h;
		h = hold;
		for (int i = 0; i <= w.len(); i++) begin
			if (i == fault_at) begin
				push_item(char_op, fault_ch, h);
				h = 1'b0;
			end
			if (i < w.len()) begin
				push_item(char_op, w[i], h);
				h = 1'b0;
			end
		end
		push_item(end_op, CHAR_W'($urandom_range(0, 255)), h);
	endtask

	function automatic string random_letters(int len);
		string s;
		int    r;
		s = "";
		for (int i = 0; i < len; i++) begin
			r = $urandom_range(0, 52);
			if (r < 26)
				s = $sformatf("%s%c", s, CHAR_LOWER_A + r);
			else if (r < 52)
				s = $sformatf("%s%c", s, CHAR_UPPER_A + r - 26);
			else
				s = $sformatf("%s%c", s, CHAR_APOS);
		end
		return s;
	endfunction

	// Flip the case of letters at random; the dictionary must fold it away.
	function automatic string recase(string w);
		string             s;
		logic [CHAR_W-1:0] c;
		s = "";
		for (int i = 0; i < w.len(); i++) begin
			c = w[i];
			if ((c | CASE_BIT) >= "a" && (c | CASE_BIT) <= "z")
				c = $urandom_range(0, 1) ? (c | CASE_BIT) : (c & ~CASE_BIT);
			s = $sformatf("%s%c", s, c);
		end
		return s;
	endfunction

	function automatic int word_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 6);
		if (r < 95)
			return $urandom_range(0, 12);
		return $urandom_range(13, 24);
	endfunction

	task automatic build_directed();
		queue_word("", OP_CHK_CHAR, OP_CHK_END, -1, '0, 1'b0);
		queue_word("a", OP_INS_CHAR, OP_INS_END, -1, '0, 1'b0);
		// empty insert marks the root, empty check still misses
		queue_word("", OP_INS_CHAR, OP_INS_END, -1, '0, 1'b0);
		queue_word("", OP_CHK_CHAR, OP_CHK_END, -1, '0, 1'b0);
		queue_word("z'", OP_INS_CHAR, OP_INS_END, -1, '0, 1'b0);
		queue_word("Z'", OP_CHK_CHAR, OP_CHK_END, -1, '0, 1'b0);
		// invalid character mid-word: rest ignored, nothing counted
		queue_word("Ab", OP_INS_CHAR, OP_INS_END, 1, 8'h00, 1'b0);
		// miss, then an invalid character that the miss hides
		queue_word("Q", OP_CHK_CHAR, OP_CHK_END, 1, 8'hFF, 1'b0);
		queue_word("", OP_CHK_CHAR, OP_CHK_END, 0, 8'hFF, 1'b0);
		// mixed words: the end item decides
		queue_word("a", OP_INS_CHAR, OP_CHK_END, -1, '0, 1'b0);
		queue_word("a", OP_CHK_CHAR, OP_INS_END, -1, '0, 1'b0);
		for (logic [OP_W-1:0] op = OP_SPARE_FIRST; op != OP_CLEAR; op++)
			push_item(op, CHAR_W'($urandom_range(0, 255)), 1'b0);
		// hold the clear until every pending result has drained
		push_item(OP_CLEAR, 8'hFF, 1'b1);
		queue_word("a", OP_CHK_CHAR, OP_CHK_END, -1, '0, 1'b0);
	endtask

	task automatic build_random();
		string vocab[$];
		string w;
		int    target;
		int    pick;
		int    sub;
		int    n;
		bit    hold;
		target = pending_items.size() + RANDOM_ITEMS;
		while (pending_items.size() < target) begin
			pick = $urandom_range(0, 99);
			sub  = $urandom_range(0, 4);
			hold = ($urandom_range(0, 39) == 0);
			w    = (vocab.size() != 0) ? vocab[$urandom_range(0, vocab.size() - 1)] : "";
			if (pick < 38) begin
				if (vocab.size() == 0 || sub < 2)
					w = random_letters(word_length());
				else if (sub == 4)
					w = $sformatf("%s%s", w, random_letters($urandom_range(1, 3)));
				queue_word(recase(w), OP_INS_CHAR, OP_INS_END, -1, '0, hold);
				if (vocab.size() < 300)
					vocab.push_back(w);
			end else if (pick < 78) begin
				if (sub == 2 && w.len() > 0) begin
					n = $urandom_range(0, w.len());
					w = (n == 0) ? "" : w.substr(0, n - 1);
				end else if (sub == 3) begin
					w = $sformatf("%s%s", w, random_letters($urandom_range(1, 2)));
				end else if (sub == 4) begin
					w = random_letters(word_length());
				end
				queue_word(recase(w), OP_CHK_CHAR, OP_CHK_END, -1, '0, hold);
			end else if (pick < 88) begin
				n = $urandom_range(0, 8);
				for (int i = 0; i < n; i++)
					push_item($urandom_range(0, 1) ? OP_INS_CHAR : OP_CHK_CHAR,
					          (i == 0 && w.len() > 0) ? w[0] : random_letters(1).getc(0),
					          hold && i == 0);
				push_item($urandom_range(0, 1) ? OP_INS_END : OP_CHK_END,
				          CHAR_W'($urandom_range(0, 255)), hold && n == 0);
			end else if (pick < 96) begin
				if (sub < 3)
					w = random_letters(word_length());
				queue_word(w, sub[0] ? OP_INS_CHAR : OP_CHK_CHAR,
				           sub[0] ? OP_INS_END : OP_CHK_END,
				           $urandom_range(0, w.len()), CHAR_W'($urandom_range(0, 255)), hold);
			end else if (pick < 99) begin
				push_item(OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)),
				          CHAR_W'($urandom_range(0, 255)), 1'b0);
			end else begin
				push_item(OP_CLEAR, CHAR_W'($urandom_range(0, 255)), hold);
				vocab.delete();
			end
		end
	endtask

	initial begin
		item_ch.valid     = 1'b0;
		item_ch.operation = OP_CLEAR;
		item_ch.character = '0;
		result_ch.ready   = 1'b0;
		arst_n            = 1'b0;
		clear_dictionary();
		build_directed();
		build_random();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (pending_items.size() != 0 || item_ch.valid || expected_word_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_word_results.size() != 0) begin
			$error("%0d word results never arrived", expected_word_results.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#25_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
